>>> rtl/core/plist_pkg.sv
`default_nettype none

package plist_pkg;

   // request kinds
   localparam logic [2:0] KIND_PUSH_TOP     = 3'd0;
   localparam logic [2:0] KIND_APPEND       = 3'd1;
   localparam logic [2:0] KIND_INSERT_AT    = 3'd2;
   localparam logic [2:0] KIND_POP_TOP      = 3'd3;
   localparam logic [2:0] KIND_REMOVE_BOTTOM = 3'd4;
   localparam logic [2:0] KIND_REMOVE_AT    = 3'd5;

   localparam int KIND_W   = 3;
   localparam int POS_W    = 5;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;   // latch the request fields
      logic execute;   // perform the operation and present the result
   } cmd_type;

endpackage

`default_nettype wire

>>> rtl/core/plist_ctrl.sv
`default_nettype none

module plist_ctrl
   import plist_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      busy        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/plist_datapath.sv
`default_nettype none

module plist_datapath
   import plist_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [POS_W-1:0]    req_position,
   input  wire logic [WORD_W-1:0]   req_value,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [WORD_W-1:0]        rsp_removed_value,
   output logic [COUNT_W-1:0]       rsp_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // latched request
   logic [KIND_W-1:0]  kind_ff;
   logic [POS_W-1:0]   position_ff;
   logic [WORD_W-1:0]  value_ff;

   // list storage: a row of cells, each shifting to or from its neighbor
   logic [WORD_W-1:0]  entries_ff [DEPTH];
   logic [WORD_W-1:0]  entries_in [DEPTH];
   logic [CNT_W-1:0]   entry_count_ff;
   logic [CNT_W-1:0]   entry_count_in;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [WORD_W-1:0]  rsp_removed_value_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   status_type         status;
   logic [CMP_W-1:0]   count_ext;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   target;
   logic [CMP_W-1:0]   count_next_ext;
   logic               do_ins;
   logic               do_rem;
   logic [WORD_W-1:0]  sel_word;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= req_kind;
         position_ff <= req_position;
         value_ff    <= req_value;
      end
   end

   always_comb begin
      count_ext = CMP_W'(entry_count_ff);
      pos_ext   = CMP_W'(position_ff);
      status    = STATUS_OK;
      target    = '0;
      do_ins    = 1'b0;
      do_rem    = 1'b0;
      unique case (kind_ff)
         KIND_PUSH_TOP, KIND_APPEND, KIND_INSERT_AT: begin
            if (count_ext >= CMP_W'(DEPTH)) begin
               status = STATUS_FULL;
            end else begin
               if (kind_ff == KIND_PUSH_TOP) begin
                  target = '0;
               end else if (kind_ff == KIND_APPEND) begin
                  target = count_ext;
               end else begin
                  target = pos_ext;
               end
               if (target > count_ext) begin
                  status = STATUS_NOT_FOUND;
               end else begin
                  do_ins = 1'b1;
               end
            end
         end
         KIND_POP_TOP, KIND_REMOVE_BOTTOM, KIND_REMOVE_AT: begin
            if (count_ext == '0) begin
               status = STATUS_EMPTY;
            end else begin
               if (kind_ff == KIND_POP_TOP) begin
                  target = '0;
               end else if (kind_ff == KIND_REMOVE_BOTTOM) begin
                  target = count_ext - CMP_W'(1);
               end else begin
                  target = pos_ext;
               end
               if (target >= count_ext) begin
                  status = STATUS_NOT_FOUND;
               end else begin
                  do_rem = 1'b1;
               end
            end
         end
         default: begin
            // unused kinds leave the list alone
         end
      endcase

      if (do_ins) begin
         count_next_ext = count_ext + CMP_W'(1);
      end else if (do_rem) begin
         count_next_ext = count_ext - CMP_W'(1);
      end else begin
         count_next_ext = count_ext;
      end
      entry_count_in = count_next_ext[CNT_W-1:0];
   end

   // word leaving the list: AND-OR select across the cells
   always_comb begin
      sel_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CMP_W'(i) == target) begin
            sel_word = sel_word | entries_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
         if (do_ins) begin
            if (CMP_W'(i) == target) begin
               entries_in[i] = value_ff;
            end else if (i > 0 && CMP_W'(i) > target) begin
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_rem) begin
            if (i < DEPTH - 1 && CMP_W'(i) >= target) begin
               entries_in[i] = entries_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         for (int i = 0; i < DEPTH; i++) begin
            entries_ff[i] <= entries_in[i];
         end
         rsp_status_ff        <= status;
         rsp_removed_value_ff <= do_rem ? sel_word : '0;
         rsp_count_ff         <= count_next_ext[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.execute;
         if (cmd.execute) begin
            entry_count_ff <= entry_count_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_value_ff;
   assign rsp_count         = rsp_count_ff;

endmodule

`default_nettype wire

>>> rtl/core/positional_list_engine.sv
// Flow: an accepted item's request is latched, the execute state then updates all list
//   cells together, and the registered result is strobed on rsp_valid.
// Items: a new item is accepted only in the idle state, never while one executes;
//   busy is high during the execute state. Results cannot be stalled.
// Reset: synchronous, active high; empties the list, cell contents are kept.
`default_nettype none

module positional_list_engine
   import plist_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [POS_W-1:0]    req_position,
   input  wire logic [WORD_W-1:0]   req_value,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [WORD_W-1:0]        rsp_removed_value,
   output logic [COUNT_W-1:0]       rsp_count
);

   cmd_type cmd;

   plist_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   plist_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_kind),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_count         (rsp_count)
   );

endmodule

`default_nettype wire

>>> rtl/core/plist_checker.sv
`default_nettype none

module plist_checker
   import plist_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_valid,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [WORD_W-1:0]   rsp_removed_value,
   input wire logic [COUNT_W-1:0]  rsp_count
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("no result two cycles after accept");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while busy");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_removed_value == '0)
      else $error("removed word nonzero on failed item");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_count == COUNT_W'(DEPTH))
      else $error("full status with count below depth");

endmodule

bind positional_list_engine plist_checker #(
   .DEPTH (DEPTH)
) u_plist_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_removed_value (rsp_removed_value),
   .rsp_count         (rsp_count)
);

`default_nettype wire
